@@ design/spad_pkg.sv @@
`timescale 1ns / 1ps
// Package for the star pair angular distance block: types, fixed-point constants and tables.
package spad_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CORDIC_STAGES_DFLT = 20;

	localparam int RA_W = 25;
	localparam int DEC_W = 24;
	localparam int ID_W = 16;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BAND_HALF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 2'd2;

	localparam logic [CFG_W-1:0] BAND_RST = CFG_W'(18 << FRAC_BITS);
	localparam logic [CFG_W-1:0] MIN_RST = CFG_W'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic [CFG_W-1:0] MAX_RST = CFG_W'(20 << FRAC_BITS);

	// Working angle in degrees, wide enough for a right ascension and a declination.
	localparam int DEG_W = 26;
	localparam logic signed [DEG_W-1:0] FULL_TURN = DEG_W'(360 << FRAC_BITS);
	localparam logic signed [DEG_W-1:0] HALF_TURN = DEG_W'(180 << FRAC_BITS);
	localparam logic signed [DEG_W-1:0] QUARTER_TURN = DEG_W'(90 << FRAC_BITS);

	// Magnitude of a folded angle and its quotient by 45.
	localparam int MAG_W = 23;
	localparam int U_W = 18;
	localparam int DIV45_SHIFT = 30;
	localparam int DIV45_W = 25;
	localparam logic [DIV45_W-1:0] DIV45_MUL = DIV45_W'(((64'd1 << DIV45_SHIFT) + 64'd44) / 64'd45);

	localparam longint ATAN1 = 64'sd843314857;
	localparam longint HALF_ATAN1 = ATAN1 / 2;
	localparam longint FOUR_ATAN1 = ATAN1 * 4;
	localparam longint Q30_ONE = 64'sd1 << 30;
	localparam longint CORDIC_GAIN = 64'sd652032874;

	// CORDIC datapath widths.
	localparam int CW = 33;
	localparam int VW = 34;
	localparam int DOT_W = 32;

	localparam logic [29:0] ATAN_TAB [32] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	// Rounded share of the degree-to-radian conversion for a remainder modulo 45.
	function automatic logic [44:0][29:0] conv_tab();
		logic [44:0][29:0] t;
		longint e;
		for (int v = 0; v < 45; v++) begin
			e = (longint'(v) * ATAN1 + ((longint'(45) << FRAC_BITS) / 2)) / 45;
			t[v] = 30'(e);
		end
		return t;
	endfunction

	localparam logic [44:0][29:0] CONV_TAB = conv_tab();

	// Square root of 2^60 - dot^2.
	localparam int SQ_IN_W = 61;
	localparam int ROOT_W = 31;
	localparam int SQ_T_W = 63;

	// Radians in Q30 to degrees: reciprocal estimate, then correction.
	localparam longint SEP_MUL = longint'(45) << FRAC_BITS;
	localparam int SEP_SHIFT = 40;
	localparam logic [63:0] SEP_RECIP = (64'(SEP_MUL) << SEP_SHIFT) / 64'(ATAN1);
	localparam int EST_W = 25;
	localparam int NUM_W = 55;
	localparam int ANG_W = 32;

	typedef struct packed {
		logic [RA_W-1:0] ref_ra;
		logic signed [DEC_W-1:0] ref_dec;
		logic [RA_W-1:0] cand_ra;
		logic signed [DEC_W-1:0] cand_dec;
		logic [ID_W-1:0] cand_id;
	} pair_t;

	typedef struct packed {
		logic [ID_W-1:0] star_id;
		logic in_band;
		logic [CFG_W-1:0] separation;
		logic accepted;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] cosv;
		logic signed [CW-1:0] sinv;
	} sincos_t;

	typedef struct packed {
		logic vld;
		logic [ID_W-1:0] id;
		logic in_band;
	} meta_t;

endpackage

@@ design/spad_sincos.sv @@
`timescale 1ns / 1ps
// Pipelined cosine and sine of an angle in fixed-point degrees by CORDIC rotation.
module spad_sincos import spad_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DFLT
) (
	input logic clk,
	input logic en,
	input logic signed [DEG_W-1:0] deg,
	output sincos_t cs
);

	logic signed [DEG_W-1:0] a1, a2, a3;
	logic flip_b;
	logic signed [DEG_W-1:0] a_sa;
	logic [MAG_W-1:0] mag_sb, mag_sc;
	logic neg_sb, neg_sc, flip_sb, flip_sc;
	logic [MAG_W+DIV45_W-1:0] u_prod;
	logic [U_W-1:0] u_sc;
	logic [U_W+5:0] u45;
	logic [5:0] rem45;
	logic [U_W+29:0] z_prod;
	logic signed [CW-1:0] z_abs, z_d;

	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [CW-1:0] z_s [0:STAGES];
	logic flip_s [0:STAGES];

	always_comb begin
		a1 = (deg >= FULL_TURN) ? deg - FULL_TURN : deg;
		a2 = (a1 > HALF_TURN) ? a1 - FULL_TURN : a1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_sa <= a2;
		end
	end

	always_comb begin
		a3 = a_sa;
		flip_b = 1'b0;
		if (a_sa > QUARTER_TURN) begin
			a3 = a_sa - HALF_TURN;
			flip_b = 1'b1;
		end else if (a_sa < -QUARTER_TURN) begin
			a3 = a_sa + HALF_TURN;
			flip_b = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_sb <= MAG_W'(a3[DEG_W-1] ? -a3 : a3);
			neg_sb <= a3[DEG_W-1];
			flip_sb <= flip_b;
		end
	end

	assign u_prod = (MAG_W+DIV45_W)'(mag_sb) * (MAG_W+DIV45_W)'(DIV45_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			u_sc <= U_W'(u_prod >> DIV45_SHIFT);
			mag_sc <= mag_sb;
			neg_sc <= neg_sb;
			flip_sc <= flip_sb;
		end
	end

	always_comb begin
		u45 = (U_W+6)'(u_sc) * (U_W+6)'(45);
		rem45 = 6'(mag_sc - MAG_W'(u45));
		z_prod = (U_W+30)'(u_sc) * (U_W+30)'(ATAN1) + (U_W+30)'(CONV_TAB[rem45]);
		z_abs = CW'(z_prod >> FRAC_BITS);
		z_d = neg_sc ? -z_abs : z_abs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CW'(CORDIC_GAIN);
			y_s[0] <= '0;
			z_s[0] <= z_d;
			flip_s[0] <= flip_sc;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - CW'(ATAN_TAB[i]);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + CW'(ATAN_TAB[i]);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs.cosv <= flip_s[STAGES] ? -x_s[STAGES] : x_s[STAGES];
			cs.sinv <= flip_s[STAGES] ? -y_s[STAGES] : y_s[STAGES];
		end
	end

endmodule

@@ design/spad_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage.
module spad_isqrt import spad_pkg::*; (
	input logic clk,
	input logic en,
	input logic [SQ_IN_W-1:0] v,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_IN_W-1:0] rem_s [0:ROOT_W-1];
	logic [ROOT_W-1:0] r_s [0:ROOT_W-1];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int B = ROOT_W - 1 - j;
		logic [SQ_IN_W-1:0] rem_in;
		logic [ROOT_W-1:0] r_in;
		logic [SQ_T_W-1:0] trial;
		logic ge;

		if (j == 0) begin : g_first
			assign rem_in = v;
			assign r_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign r_in = r_s[j-1];
		end

		assign trial = (SQ_T_W'(r_in) << (B + 1)) + (SQ_T_W'(1) << (2 * B));
		assign ge = SQ_T_W'(rem_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? SQ_IN_W'(SQ_T_W'(rem_in) - trial) : rem_in;
				r_s[j] <= ge ? (r_in | (ROOT_W'(1) << B)) : r_in;
			end
		end
	end

	assign root = r_s[ROOT_W-1];

endmodule

@@ design/star_pair_angular_distance_top.sv @@
`timescale 1ns / 1ps
// Top level of the star pair angular distance pipeline.
//
//   channel  dir  handshake              beat
//   pair     in   pair_valid/pair_stall  pair_t: two stars and the candidate id
//   result   out  result_valid/stall     result_t: id, band flag, separation, accept
//   cfg      in   cfg_we                 cfg_idx selects band, min or max angle
//
// One pair is taken every cycle while pair_stall is low; each result passes through
// the two CORDIC pipelines and the 31-stage square root.
// Reset clears the valid bits of every stage and loads the default configuration.
// A stalled result freezes the whole pipeline, and pair_stall is raised for that cycle.
module star_pair_angular_distance_top import spad_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DFLT
) (
	input logic clk,
	input logic arst_n,
	input logic pair_valid,
	output logic pair_stall,
	input pair_t pair,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_W-1:0] cfg_data
);

	localparam int MD = 2 * CORDIC_STAGES + 45;

	logic en;
	logic [CFG_W-1:0] band_q, min_q, max_q;
	logic signed [DEG_W-1:0] rdec_x, cdec_x, band_x;
	logic in_band_c;

	pair_t pair_s1;
	meta_t meta_s [0:MD-1];

	sincos_t rra_cs, rdec_cs, cra_cs, cdec_cs;

	logic signed [2*CW-1:0] p_x0, p_y0, p_x1, p_y1;
	logic signed [CW-1:0] x0_s2, y0_s2, x1_s2, y1_s2, sd0_s2, sd1_s2;
	logic signed [2*CW-1:0] xx_s3, yy_s3, zz_s3;
	logic signed [2*CW+1:0] dsum, dshift;
	logic signed [DOT_W-1:0] dot_c, dot_s4, dot_s5;
	logic signed [2*DOT_W-1:0] dsq;
	logic [63:0] sq_full;
	logic [SQ_IN_W-1:0] sq_s5;
	logic [ROOT_W-1:0] root;
	logic signed [DOT_W-1:0] dot_dl_s [0:ROOT_W-1];

	logic signed [VW-1:0] vx_s [0:CORDIC_STAGES];
	logic signed [VW-1:0] vy_s [0:CORDIC_STAGES];
	logic signed [CW-1:0] vz_s [0:CORDIC_STAGES];
	logic vneg_s [0:CORDIC_STAGES];
	logic signed [VW-1:0] dot_abs;

	logic signed [VW-1:0] ang_full;
	logic [ANG_W-1:0] ang_s6;
	logic [63:0] est_p, num_p;
	logic [EST_W-1:0] est_s7, est_s8;
	logic [NUM_W-1:0] num_s7, num_s8, prod_s8, rem;
	logic [EST_W:0] sep_full;
	logic [CFG_W-1:0] sep;

	logic res_vld_q;
	result_t res_q;

	assign en = !(res_vld_q && result_stall);
	assign pair_stall = !en;
	assign result_valid = res_vld_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= BAND_RST;
			min_q <= MIN_RST;
			max_q <= MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BAND_HALF: band_q <= cfg_data;
				CFG_MIN_ANGLE: min_q <= cfg_data;
				CFG_MAX_ANGLE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rdec_x = DEG_W'(pair.ref_dec);
		cdec_x = DEG_W'(pair.cand_dec);
		band_x = DEG_W'({1'b0, band_q});
		in_band_c = (cdec_x < rdec_x + band_x) && (cdec_x > rdec_x - band_x);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MD; k++) begin
				meta_s[k] <= '0;
			end
		end else if (en) begin
			meta_s[0] <= '{vld: pair_valid, id: pair.cand_id, in_band: in_band_c};
			for (int k = 1; k < MD; k++) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	spad_sincos #(.STAGES(CORDIC_STAGES)) u_rra (
		.clk(clk), .en(en), .deg(DEG_W'({1'b0, pair_s1.ref_ra})), .cs(rra_cs)
	);
	spad_sincos #(.STAGES(CORDIC_STAGES)) u_rdec (
		.clk(clk), .en(en), .deg(DEG_W'(pair_s1.ref_dec)), .cs(rdec_cs)
	);
	spad_sincos #(.STAGES(CORDIC_STAGES)) u_cra (
		.clk(clk), .en(en), .deg(DEG_W'({1'b0, pair_s1.cand_ra})), .cs(cra_cs)
	);
	spad_sincos #(.STAGES(CORDIC_STAGES)) u_cdec (
		.clk(clk), .en(en), .deg(DEG_W'(pair_s1.cand_dec)), .cs(cdec_cs)
	);

	always_comb begin
		p_x0 = rra_cs.cosv * rdec_cs.cosv;
		p_y0 = rra_cs.sinv * rdec_cs.cosv;
		p_x1 = cra_cs.cosv * cdec_cs.cosv;
		p_y1 = cra_cs.sinv * cdec_cs.cosv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_s2 <= CW'(p_x0 >>> 30);
			y0_s2 <= CW'(p_y0 >>> 30);
			x1_s2 <= CW'(p_x1 >>> 30);
			y1_s2 <= CW'(p_y1 >>> 30);
			sd0_s2 <= rdec_cs.sinv;
			sd1_s2 <= cdec_cs.sinv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s3 <= x0_s2 * x1_s2;
			yy_s3 <= y0_s2 * y1_s2;
			zz_s3 <= sd0_s2 * sd1_s2;
		end
	end

	always_comb begin
		dsum = (2*CW+2)'(xx_s3) + (2*CW+2)'(yy_s3) + (2*CW+2)'(zz_s3);
		dshift = dsum >>> 30;
		if (dshift > Q30_ONE) begin
			dot_c = DOT_W'(Q30_ONE);
		end else if (dshift < -Q30_ONE) begin
			dot_c = DOT_W'(-Q30_ONE);
		end else begin
			dot_c = DOT_W'(dshift);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s4 <= dot_c;
		end
	end

	always_comb begin
		dsq = dot_s4 * dot_s4;
		sq_full = (64'd1 << 60) - 64'(dsq);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5 <= SQ_IN_W'(sq_full);
			dot_s5 <= dot_s4;
		end
	end

	spad_isqrt u_isqrt (
		.clk(clk), .en(en), .v(sq_s5), .root(root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dot_dl_s[0] <= dot_s5;
			for (int k = 1; k < ROOT_W; k++) begin
				dot_dl_s[k] <= dot_dl_s[k-1];
			end
		end
	end

	assign dot_abs = dot_dl_s[ROOT_W-1][DOT_W-1] ? -VW'(dot_dl_s[ROOT_W-1])
		: VW'(dot_dl_s[ROOT_W-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0] <= dot_abs;
			vy_s[0] <= VW'({1'b0, root});
			vz_s[0] <= '0;
			vneg_s[0] <= dot_dl_s[ROOT_W-1][DOT_W-1];
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (!vy_s[i][VW-1]) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + CW'(ATAN_TAB[i]);
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - CW'(ATAN_TAB[i]);
				end
				vneg_s[i+1] <= vneg_s[i];
			end
		end
	end

	assign ang_full = vneg_s[CORDIC_STAGES] ? VW'(FOUR_ATAN1) - VW'(vz_s[CORDIC_STAGES])
		: VW'(vz_s[CORDIC_STAGES]);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s6 <= ang_full[VW-1] ? '0 : ANG_W'(ang_full);
		end
	end

	always_comb begin
		est_p = 64'(ang_s6) * SEP_RECIP;
		num_p = 64'(ang_s6) * 64'(SEP_MUL) + 64'(HALF_ATAN1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			est_s7 <= EST_W'(est_p >> SEP_SHIFT);
			num_s7 <= NUM_W'(num_p);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s8 <= NUM_W'(64'(est_s7) * 64'(ATAN1));
			num_s8 <= num_s7;
			est_s8 <= est_s7;
		end
	end

	always_comb begin
		rem = num_s8 - prod_s8;
		if (rem >= NUM_W'(2 * ATAN1)) begin
			sep_full = (EST_W+1)'(est_s8) + (EST_W+1)'(2);
		end else if (rem >= NUM_W'(ATAN1)) begin
			sep_full = (EST_W+1)'(est_s8) + (EST_W+1)'(1);
		end else begin
			sep_full = (EST_W+1)'(est_s8);
		end
		sep = (sep_full > (EST_W+1)'({CFG_W{1'b1}})) ? {CFG_W{1'b1}} : CFG_W'(sep_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= meta_s[MD-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.star_id <= meta_s[MD-1].id;
			res_q.in_band <= meta_s[MD-1].in_band;
			res_q.separation <= sep;
			res_q.accepted <= meta_s[MD-1].in_band && (sep > min_q) && (sep < max_q);
		end
	end

`ifndef SYNTHESIS
	a_acc_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.accepted || result.in_band))
		else $error("accepted pair outside declination band");

	a_acc_window: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.accepted) |->
		(result.separation > min_q && result.separation < max_q))
		else $error("accepted pair outside angle window");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && !pair_stall) |=> meta_s[0].vld)
		else $error("taken pair beat missing from first stage");
`endif

endmodule
